[rtl/core/slrg_pkg.sv]
`timescale 1ns / 1ps
package slrg_pkg;

	localparam int unsigned TBL_LEN = 55;

	localparam logic [5:0]  TBL_LAST  = 6'd54;
	localparam logic [5:0]  FILL_LAST = 6'd53;
	localparam logic [5:0]  IDX_FP    = 6'd55;
	localparam logic [5:0]  IDX_SP    = 6'd56;
	localparam logic [5:0]  PTR_MAX   = 6'd55;
	localparam logic [5:0]  SEED_SP   = 6'd31;
	localparam logic [5:0]  LAG_OFS   = 6'd31;
	localparam logic [5:0]  POS_STEP  = 6'd21;
	localparam logic [31:0] MAGIC     = 32'd161803398;
	localparam logic [31:0] MOD_BIG   = 32'd1000000000;
	localparam logic [31:0] MAG_MAX   = 32'd999999999;

	typedef enum logic [1:0] {
		CMD_SEED    = 2'd0,
		CMD_NEXT    = 2'd1,
		CMD_SAVE    = 2'd2,
		CMD_RESTORE = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_DISPATCH,
		ST_SEED_MAG,
		ST_SEED_MJ,
		ST_SEED_TOP,
		ST_SEED_FILL,
		ST_WARM_INIT,
		ST_WARM,
		ST_SAVE_RD,
		ST_SAVE_FP,
		ST_SAVE_SP
	} step_t;

	typedef enum logic [1:0] {
		J_DISPATCH,
		J_GOTO,
		J_LOOP
	} jmp_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_CLR,
		CNT_INC
	} cnt_op_t;

	typedef enum logic [2:0] {
		R_NONE,
		R_MAG,
		R_MJ,
		R_FILL,
		R_PTR_SEED
	} reg_op_t;

	typedef enum logic [2:0] {
		S_NONE,
		S_WR_MJ,
		S_WR_MK,
		S_WARM,
		S_SHOW_RAM,
		S_SHOW_FP,
		S_SHOW_SP
	} s1_op_t;

	typedef enum logic [1:0] {
		EM_SUB,
		EM_RAM,
		EM_DATA
	} emit_sel_t;

	// one microcode word
	typedef struct packed {
		logic       busy;
		jmp_t       jmp;
		step_t      target;
		cnt_op_t    cnt_op;
		logic [5:0] cnt_last;
		logic       chk_pass;
		reg_op_t    reg_op;
		s1_op_t     s1_op;
	} ctl_t;

	// control handed from the sequencer to the datapath
	typedef struct packed {
		logic       accept;
		reg_op_t    reg_op;
		s1_op_t     s1_op;
		logic [5:0] cnt;
	} dp_ctl_t;

	// a - b, then add 10^9 once if the difference is negative
	function automatic logic [31:0] sub_wrap(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d[31] ? (d + MOD_BIG) : d;
	endfunction

	// step a pointer cyclically through 1..55
	function automatic logic [5:0] ptr_adv(input logic [5:0] p);
		return (p >= PTR_MAX) ? 6'd1 : (p + 6'd1);
	endfunction

endpackage

[rtl/core/slrg_seq.sv]
`timescale 1ns / 1ps
module slrg_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        cmd,
	output logic              busy,
	output slrg_pkg::dp_ctl_t ctl
);
	import slrg_pkg::*;

	step_t      step_q, step_d;
	logic [5:0] cnt_q;
	logic [1:0] pass_q;
	ctl_t       uw;
	logic       accept;
	logic       done;

	// control store
	function automatic ctl_t rom(input step_t s);
		ctl_t w;
		w.busy     = 1'b1;
		w.jmp      = J_GOTO;
		w.target   = ST_DISPATCH;
		w.cnt_op   = CNT_HOLD;
		w.cnt_last = TBL_LAST;
		w.chk_pass = 1'b0;
		w.reg_op   = R_NONE;
		w.s1_op    = S_NONE;
		case (s)
			ST_DISPATCH: begin
				w.busy   = 1'b0;
				w.jmp    = J_DISPATCH;
				w.cnt_op = CNT_CLR;
			end
			ST_SEED_MAG: begin
				w.reg_op = R_MAG;
				w.target = ST_SEED_MJ;
			end
			ST_SEED_MJ: begin
				w.reg_op = R_MJ;
				w.target = ST_SEED_TOP;
			end
			ST_SEED_TOP: begin
				w.s1_op  = S_WR_MJ;
				w.target = ST_SEED_FILL;
			end
			ST_SEED_FILL: begin
				w.reg_op   = R_FILL;
				w.s1_op    = S_WR_MK;
				w.cnt_op   = CNT_INC;
				w.cnt_last = FILL_LAST;
				w.jmp      = J_LOOP;
				w.target   = ST_WARM_INIT;
			end
			ST_WARM_INIT: begin
				w.reg_op = R_PTR_SEED;
				w.cnt_op = CNT_CLR;
				w.target = ST_WARM;
			end
			ST_WARM: begin
				w.s1_op    = S_WARM;
				w.cnt_op   = CNT_INC;
				w.chk_pass = 1'b1;
				w.jmp      = J_LOOP;
				w.target   = ST_DISPATCH;
			end
			ST_SAVE_RD: begin
				w.s1_op  = S_SHOW_RAM;
				w.cnt_op = CNT_INC;
				w.jmp    = J_LOOP;
				w.target = ST_SAVE_FP;
			end
			ST_SAVE_FP: begin
				w.s1_op  = S_SHOW_FP;
				w.target = ST_SAVE_SP;
			end
			ST_SAVE_SP: begin
				w.s1_op  = S_SHOW_SP;
				w.target = ST_DISPATCH;
			end
			default: begin
				w.target = ST_DISPATCH;
			end
		endcase
		return w;
	endfunction

	// outputs of the current step
	always_comb begin
		uw         = rom(step_q);
		busy       = uw.busy;
		accept     = start && !uw.busy;
		done       = (cnt_q == uw.cnt_last) && (!uw.chk_pass || (pass_q == 2'd3));
		ctl.accept = accept;
		ctl.reg_op = uw.reg_op;
		ctl.s1_op  = uw.s1_op;
		ctl.cnt    = cnt_q;
	end

	// next step
	always_comb begin
		step_d = step_q;
		case (uw.jmp)
			J_DISPATCH: begin
				if (accept) begin
					case (cmd_t'(cmd))
						CMD_SEED: step_d = ST_SEED_MAG;
						CMD_SAVE: step_d = ST_SAVE_RD;
						default:  step_d = ST_DISPATCH;
					endcase
				end
			end
			J_GOTO: step_d = uw.target;
			J_LOOP: begin
				if (done) begin
					step_d = uw.target;
				end
			end
			default: step_d = ST_DISPATCH;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_DISPATCH;
			cnt_q  <= '0;
			pass_q <= '0;
		end else begin
			step_q <= step_d;
			case (uw.cnt_op)
				CNT_CLR: begin
					cnt_q  <= '0;
					pass_q <= '0;
				end
				CNT_INC: begin
					if (cnt_q == TBL_LAST) begin
						cnt_q  <= '0;
						pass_q <= pass_q + 2'd1;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

endmodule

[rtl/core/slrg_dp.sv]
`timescale 1ns / 1ps
module slrg_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  slrg_pkg::dp_ctl_t  ctl,
	input  logic [1:0]         cmd,
	input  logic signed [30:0] seed,
	input  logic signed [31:0] restore_word,
	input  logic [5:0]         restore_index,
	output logic               strobe,
	output logic signed [31:0] value,
	output logic [5:0]         word_index,
	output logic               last
);
	import slrg_pkg::*;

	logic [31:0]        mem [TBL_LEN];
	logic [TBL_LEN-1:0] valid_q;

	logic [5:0]  fp_q, sp_q, nfp, nsp;
	logic [31:0] mj_q, mk_q;
	logic [5:0]  pos_q, pos_nxt;
	logic [6:0]  pos_sum, other_sum;
	logic [5:0]  other;
	logic        is_next, is_restore, is_seed;

	logic [5:0]  raddr_a, raddr_b;
	logic [31:0] mem_a_s1, mem_b_s1, wdf_s1;
	logic        hit_a_s1, hit_b_s1, vld_a_s1, vld_b_s1;
	logic [31:0] rda, rdb, sub_res;

	logic        wr_en_d, sub_d, emit_d, last_d;
	logic [5:0]  wa_d, idx_d;
	logic [31:0] data_d;
	emit_sel_t   esel_d;

	logic        wr_en_s1, sub_s1, emit_s1, last_s1;
	logic [5:0]  wa_s1, idx_s1;
	logic [31:0] data_s1;
	emit_sel_t   esel_s1;

	logic [31:0] wd;

	// seed magnitude, saturated
	function automatic logic [31:0] seed_mag(input logic [30:0] raw);
		logic [31:0] m;
		m = raw[30] ? (32'h8000_0000 - {1'b0, raw}) : {1'b0, raw};
		return (m > MAG_MAX) ? MAG_MAX : m;
	endfunction

	function automatic logic [5:0] clamp_ptr(input logic [31:0] w);
		logic [5:0] r;
		if (w[31]) begin
			r = 6'd0;
		end else if (w > {26'd0, PTR_MAX}) begin
			r = PTR_MAX;
		end else begin
			r = w[5:0];
		end
		return r;
	endfunction

	always_comb begin
		is_seed    = ctl.accept && (cmd_t'(cmd) == CMD_SEED);
		is_next    = ctl.accept && (cmd_t'(cmd) == CMD_NEXT);
		is_restore = ctl.accept && (cmd_t'(cmd) == CMD_RESTORE);
		nfp        = ptr_adv(fp_q);
		nsp        = ptr_adv(sp_q);
		pos_sum    = {1'b0, pos_q} + {1'b0, POS_STEP};
		pos_nxt    = (pos_sum >= 7'(TBL_LEN)) ? 6'(pos_sum - 7'(TBL_LEN)) : pos_sum[5:0];
		other_sum  = {1'b0, ctl.cnt} + {1'b0, LAG_OFS};
		other      = (other_sum >= 7'(TBL_LEN)) ? 6'(other_sum - 7'(TBL_LEN)) : other_sum[5:0];
	end

	// read addresses
	always_comb begin
		raddr_a = ctl.cnt;
		raddr_b = other;
		if (is_next) begin
			raddr_a = nfp - 6'd1;
			raddr_b = nsp - 6'd1;
		end
	end

	// build the stage-one operation
	always_comb begin
		wr_en_d = 1'b0;
		sub_d   = 1'b0;
		emit_d  = 1'b0;
		last_d  = 1'b0;
		wa_d    = ctl.cnt;
		idx_d   = ctl.cnt;
		data_d  = mk_q;
		esel_d  = EM_SUB;
		case (ctl.s1_op)
			S_WR_MJ: begin
				wr_en_d = 1'b1;
				wa_d    = TBL_LAST;
				data_d  = mj_q;
			end
			S_WR_MK: begin
				wr_en_d = 1'b1;
				wa_d    = pos_q - 6'd1;
			end
			S_WARM: begin
				wr_en_d = 1'b1;
				sub_d   = 1'b1;
			end
			S_SHOW_RAM: begin
				emit_d = 1'b1;
				esel_d = EM_RAM;
			end
			S_SHOW_FP: begin
				emit_d = 1'b1;
				esel_d = EM_DATA;
				data_d = {26'd0, fp_q};
				idx_d  = IDX_FP;
			end
			S_SHOW_SP: begin
				emit_d = 1'b1;
				esel_d = EM_DATA;
				data_d = {26'd0, sp_q};
				idx_d  = IDX_SP;
				last_d = 1'b1;
			end
			default: begin
				wr_en_d = 1'b0;
			end
		endcase
		if (is_next) begin
			wr_en_d = 1'b1;
			sub_d   = 1'b1;
			wa_d    = nfp - 6'd1;
			emit_d  = 1'b1;
			esel_d  = EM_SUB;
			idx_d   = 6'd0;
			last_d  = 1'b1;
		end
		if (is_restore && (restore_index < 6'(TBL_LEN))) begin
			wr_en_d = 1'b1;
			sub_d   = 1'b0;
			wa_d    = restore_index;
			data_d  = restore_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_en_s1 <= 1'b0;
			emit_s1  <= 1'b0;
		end else begin
			wr_en_s1 <= wr_en_d;
			emit_s1  <= emit_d;
		end
	end

	always_ff @(posedge clk) begin
		sub_s1  <= sub_d;
		last_s1 <= last_d;
		wa_s1   <= wa_d;
		idx_s1  <= idx_d;
		data_s1 <= data_d;
		esel_s1 <= esel_d;
	end

	// table memory: one write port, two registered read ports, write forwarding
	assign sub_res = sub_wrap(rda, rdb);
	assign wd      = sub_s1 ? sub_res : data_s1;

	always_ff @(posedge clk) begin
		if (wr_en_s1) begin
			mem[wa_s1] <= wd;
		end
		mem_a_s1 <= mem[raddr_a];
		mem_b_s1 <= mem[raddr_b];
		vld_a_s1 <= valid_q[raddr_a];
		vld_b_s1 <= valid_q[raddr_b];
		hit_a_s1 <= wr_en_s1 && (wa_s1 == raddr_a);
		hit_b_s1 <= wr_en_s1 && (wa_s1 == raddr_b);
		wdf_s1   <= wd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en_s1) begin
			valid_q[wa_s1] <= 1'b1;
		end
	end

	assign rda = hit_a_s1 ? wdf_s1 : (vld_a_s1 ? mem_a_s1 : 32'd0);
	assign rdb = hit_b_s1 ? wdf_s1 : (vld_b_s1 ? mem_b_s1 : 32'd0);

	// seeding temporaries
	always_ff @(posedge clk) begin
		if (is_seed) begin
			mj_q <= {1'b0, seed};
		end
		case (ctl.reg_op)
			R_MAG: mj_q <= seed_mag(mj_q[30:0]);
			R_MJ: begin
				mj_q  <= MAGIC - mj_q;
				mk_q  <= 32'd1;
				pos_q <= POS_STEP;
			end
			R_FILL: begin
				mk_q  <= sub_wrap(mj_q, mk_q);
				mj_q  <= mk_q;
				pos_q <= pos_nxt;
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_q <= '0;
			sp_q <= '0;
		end else begin
			if (is_next) begin
				fp_q <= nfp;
				sp_q <= nsp;
			end
			if (is_restore && (restore_index == IDX_FP)) begin
				fp_q <= clamp_ptr(restore_word);
			end
			if (is_restore && (restore_index == IDX_SP)) begin
				sp_q <= clamp_ptr(restore_word);
			end
			if (ctl.reg_op == R_PTR_SEED) begin
				fp_q <= '0;
				sp_q <= SEED_SP;
			end
		end
	end

	always_comb begin
		case (esel_s1)
			EM_SUB:  value = sub_res;
			EM_RAM:  value = rda;
			EM_DATA: value = data_s1;
			default: value = data_s1;
		endcase
	end

	assign strobe     = emit_s1;
	assign word_index = idx_s1;
	assign last       = last_s1;

endmodule

[rtl/core/subtractive_lagged_random_generator_top.sv]
`timescale 1ns / 1ps
// Next: result in the cycle after acceptance, one per cycle; busy stays low.
// Save: first result after the step and stage-one registers, then one a cycle.
// Seed: no result. Save and seed: busy while they run. Restore: no result, busy low.
// Reset (arst_n low): pointers to zero, table reads as zero; no clearing pass.
// The receiver cannot stall: each result is shown for one cycle under strobe.
module subtractive_lagged_random_generator_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         cmd,
	input  logic signed [30:0] seed,
	input  logic signed [31:0] restore_word,
	input  logic [5:0]         restore_index,
	output logic               strobe,
	output logic signed [31:0] value,
	output logic [5:0]         word_index,
	output logic               last
);
	import slrg_pkg::*;

	dp_ctl_t ctl;

	// Sequencer: step counter over a small control store, plus the loop
	// counter that addresses the table during seeding and save. In its
	// dispatch step it takes a word when start is high and branches on cmd:
	// next and restore are handled in the dispatch step itself, seed and
	// save run their microprogram and hold busy high until they return.
	slrg_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.ctl    (ctl)
	);

	// Datapath: the 55-word table (two read ports, one write port, write
	// forwarding so back-to-back draws see the word the previous draw wrote),
	// the two pointers, the seeding temporaries and a single write/show stage.
	// Every table write and every result goes through that stage, so writes
	// from a draw, a restore or the seeding loops never collide.
	slrg_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.cmd           (cmd),
		.seed          (seed),
		.restore_word  (restore_word),
		.restore_index (restore_index),
		.strobe        (strobe),
		.value         (value),
		.word_index    (word_index),
		.last          (last)
	);

endmodule
